// ===== rtl/clmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the curvilinear momentum terms block.
// Used by clmt_flux_calc, curvilinear_momentum_terms_top and the testbench.
package clmt_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 11;
  localparam int ROW_W          = 10;
  localparam int MAX_ROW_DEF    = 1024;
  localparam int MAX_LAYER_ROWS = 1024;
  localparam int CFG_ADDR_W     = 1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_PER_LAYER = 1'b1;

  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 11'd1024;

  // Stage enables from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic load;
    logic mul1;
    logic diff;
    logic mul2;
    logic mul3;
  } clmt_ctl_t;

  // Finished result of one cell.
  typedef struct packed {
    logic [DATA_W-1:0] ru;
    logic [DATA_W-1:0] rv;
    logic              ru_w;
    logic              rv_w;
  } clmt_res_t;

endpackage

// ===== rtl/clmt_line_store.sv =====
`timescale 1ns / 1ps
// Line store for the y fluxes of the previous row: one write and one
// registered read port. Depends on nothing else.
module clmt_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/clmt_flux_calc.sv =====
`timescale 1ns / 1ps
// Arithmetic of one cell: averaged velocities, the flux pair and the final
// right-hand side updates, one multiply level per multiply stage. Uses clmt_pkg.
module clmt_flux_calc (
  input  logic                      clk,
  input  clmt_pkg::clmt_ctl_t       ctl,
  input  logic signed [31:0]        u_here,
  input  logic signed [31:0]        u_east,
  input  logic signed [31:0]        v_here,
  input  logic signed [31:0]        v_north,
  input  logic signed [31:0]        metric_xi,
  input  logic signed [31:0]        metric_eta,
  input  logic signed [31:0]        cell_height,
  input  logic signed [31:0]        ru_in,
  input  logic signed [31:0]        rv_in,
  input  logic                      do_u,
  input  logic                      do_v,
  input  logic signed [31:0]        prev_x_flux,
  input  logic signed [31:0]        line_y_flux,
  output logic signed [31:0]        x_flux,
  output logic signed [31:0]        y_flux,
  output clmt_pkg::clmt_res_t       res
);

  // Floor of the exact 33-bit sum over two.
  function automatic logic signed [31:0] half_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  // Clamp a 33-bit value to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Q16.16 product, floor shift by 16, clamped to 32 bits.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [31:0] r;
    p = 64'(a) * 64'(b);
    if ((&p[63:47]) || !(|p[63:47])) begin
      r = p[47:16];
    end else begin
      r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

  logic signed [31:0] cv_r, cu_r, xi_r, eta_r, h_r, ru_r, rv_r;
  logic               do_u_r, do_v_r;
  logic signed [31:0] pxi_r, peta_r, d_r, c_r, fx_r, fy_r;

  // Capture the beat and form the averaged velocities.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cv_r   <= half_sum(v_here, v_north);
      cu_r   <= half_sum(u_here, u_east);
      xi_r   <= metric_xi;
      eta_r  <= metric_eta;
      h_r    <= cell_height;
      ru_r   <= ru_in;
      rv_r   <= rv_in;
      do_u_r <= do_u;
      do_v_r <= do_v;
    end
  end

  // Metric products, their difference, the height product, then the fluxes.
  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      pxi_r  <= qmul(cv_r, xi_r);
      peta_r <= qmul(cu_r, eta_r);
    end
    if (ctl.diff) begin
      d_r <= sat33(33'(pxi_r) - 33'(peta_r));
    end
    if (ctl.mul2) begin
      c_r <= qmul(h_r, d_r);
    end
    if (ctl.mul3) begin
      fx_r <= qmul(c_r, cv_r);
      fy_r <= qmul(c_r, cu_r);
    end
  end

  assign x_flux = fx_r;
  assign y_flux = fy_r;

  // Final updates against the west and south neighbor fluxes.
  always_comb begin
    res.ru   = do_u_r ? sat33(33'(ru_r) + 33'(half_sum(fx_r, prev_x_flux))) : ru_r;
    res.rv   = do_v_r ? sat33(33'(rv_r) - 33'(half_sum(fy_r, line_y_flux))) : rv_r;
    res.ru_w = do_u_r;
    res.rv_w = do_v_r;
  end

endmodule

// ===== rtl/curvilinear_momentum_terms_top.sv =====
`timescale 1ns / 1ps
// Curvilinear momentum terms: streams grid cells and updates the u and v
// right-hand sides from the curvilinear flux pair.
// Uses clmt_pkg, clmt_flux_calc and clmt_line_store.
//
// Usage:
//  - Input channel (in_*): one beat per grid cell in raster order, column
//    fastest, then rows, then layers. in_stall is high while a cell is in work.
//  - Output channel (out_*): one beat per input beat, in the same order.
//  - Configuration (cfg_*): row_length and rows_per_layer, written while idle.
//  - out_valid rises once the cell has passed through S_MUL1, S_DIFF, S_MUL2,
//    S_MUL3 and S_FIN and its result is committed to the output register.
//  - The sequencer walks one cell at a time through the three multiply levels and
//    the read-modify-write of the y flux line store, taking no new cell until idle.
//  - The output register frees the input side: a new cell is taken while a
//    result still waits. If the receiver stalls and the next result is done,
//    the sequencer holds it in the last step until the register drains.
//  - Reset clears the counters, the previous x flux and both registers to
//    their defaults. The line store is not cleared; a stored entry is used only
//    for cells outside the first row of a layer.
module curvilinear_momentum_terms_top #(
  parameter int MAX_ROW = clmt_pkg::MAX_ROW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [clmt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [clmt_pkg::CFG_W-1:0]          cfg_wdata,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_u_here,
  input  logic signed [31:0]                  in_u_east,
  input  logic signed [31:0]                  in_v_here,
  input  logic signed [31:0]                  in_v_north,
  input  logic signed [31:0]                  in_metric_xi,
  input  logic signed [31:0]                  in_metric_eta,
  input  logic signed [31:0]                  in_cell_height,
  input  logic signed [31:0]                  in_ru_in,
  input  logic signed [31:0]                  in_rv_in,
  input  logic                                in_update_u,
  input  logic                                in_update_v,
  // Output channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  out_ru_out,
  output logic signed [31:0]                  out_rv_out,
  output logic                                out_ru_written,
  output logic                                out_rv_written
);

  localparam int AW     = $clog2(MAX_ROW);
  localparam int CMPW   = (AW + 1 > clmt_pkg::CFG_W) ? AW + 1 : clmt_pkg::CFG_W;
  localparam int ROW_W  = clmt_pkg::ROW_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_DIFF,
    S_MUL2,
    S_MUL3,
    S_FIN
  } state_t;

  state_t                      state_r;
  logic [clmt_pkg::CFG_W-1:0]  row_length_r, rows_per_layer_r;
  logic [AW-1:0]               col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]            row_cnt_r, row_cnt_nxt;
  logic [AW-1:0]               col_r;
  logic signed [31:0]          prev_x_flux_r;
  logic                        out_valid_r;
  clmt_pkg::clmt_res_t         out_res_r;

  logic                        in_beat, commit;
  logic [CMPW-1:0]             row_len_eff, col_ext, col_start, col_inc;
  logic [clmt_pkg::CFG_W-1:0]  rows_eff, row_ext, row_start, row_inc;
  clmt_pkg::clmt_ctl_t         ctl;
  clmt_pkg::clmt_res_t         res;
  logic signed [31:0]          x_flux, y_flux, line_y_flux;

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign commit   = (state_r == S_FIN) && !(out_valid_r && out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r     <= clmt_pkg::CFG_LEN_RESET;
      rows_per_layer_r <= clmt_pkg::CFG_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        clmt_pkg::REG_ROW_LENGTH:     row_length_r     <= cfg_wdata;
        clmt_pkg::REG_ROWS_PER_LAYER: rows_per_layer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective lengths: zero acts as one, large values clamp to the maximum.
  always_comb begin
    row_len_eff = CMPW'(row_length_r);
    if (row_length_r == '0) begin
      row_len_eff = CMPW'(1);
    end else if (CMPW'(row_length_r) > CMPW'(MAX_ROW)) begin
      row_len_eff = CMPW'(MAX_ROW);
    end
    rows_eff = rows_per_layer_r;
    if (rows_per_layer_r == '0) begin
      rows_eff = clmt_pkg::CFG_W'(1);
    end else if (rows_per_layer_r > clmt_pkg::CFG_W'(clmt_pkg::MAX_LAYER_ROWS)) begin
      rows_eff = clmt_pkg::CFG_W'(clmt_pkg::MAX_LAYER_ROWS);
    end
  end

  // Position of the incoming cell and the counters after it.
  always_comb begin
    col_ext   = CMPW'(col_cnt_r);
    row_ext   = clmt_pkg::CFG_W'(row_cnt_r);
    col_start = (col_ext >= row_len_eff) ? '0 : col_ext;
    row_start = (row_ext >= rows_eff) ? '0 : row_ext;
    col_inc   = col_start + CMPW'(1);
    row_inc   = row_start + clmt_pkg::CFG_W'(1);
    if (col_inc >= row_len_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_cnt_nxt = col_inc[AW-1:0];
      row_cnt_nxt = row_start[ROW_W-1:0];
    end
  end

  // Counters and the column of the cell in work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_beat) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      col_r <= col_start[AW-1:0];
    end
  end

  // West neighbor flux carried from the previous cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_flux_r <= '0;
    end else if (commit) begin
      prev_x_flux_r <= x_flux;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_beat) state_r <= S_MUL1;
        S_MUL1: state_r <= S_DIFF;
        S_DIFF: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_FIN;
        S_FIN:  if (commit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ru_out     = out_res_r.ru;
  assign out_rv_out     = out_res_r.rv;
  assign out_ru_written = out_res_r.ru_w;
  assign out_rv_written = out_res_r.rv_w;

  always_comb begin
    ctl.load = in_beat;
    ctl.mul1 = (state_r == S_MUL1);
    ctl.diff = (state_r == S_DIFF);
    ctl.mul2 = (state_r == S_MUL2);
    ctl.mul3 = (state_r == S_MUL3);
  end

  clmt_flux_calc u_calc (
    .clk         (clk),
    .ctl         (ctl),
    .u_here      (in_u_here),
    .u_east      (in_u_east),
    .v_here      (in_v_here),
    .v_north     (in_v_north),
    .metric_xi   (in_metric_xi),
    .metric_eta  (in_metric_eta),
    .cell_height (in_cell_height),
    .ru_in       (in_ru_in),
    .rv_in       (in_rv_in),
    .do_u        (in_update_u && (col_start != '0)),
    .do_v        (in_update_v && (row_start != '0)),
    .prev_x_flux (prev_x_flux_r),
    .line_y_flux (line_y_flux),
    .x_flux      (x_flux),
    .y_flux      (y_flux),
    .res         (res)
  );

  // Read the stored flux of this column early, write the new one at commit.
  clmt_line_store #(
    .DEPTH (MAX_ROW),
    .AW    (AW),
    .DW    (clmt_pkg::DATA_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (ctl.mul1),
    .rd_addr (col_r),
    .rd_data (line_y_flux),
    .wr_en   (commit),
    .wr_addr (col_r),
    .wr_data (y_flux)
  );

endmodule

// ===== verif/curvilinear_momentum_terms_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for curvilinear_momentum_terms_top: directed and random grid-cell
// streams, with the expected right-hand sides computed in a small scoreboard class.
// Depends on clmt_pkg and the block's RTL only.
module curvilinear_momentum_terms_top_tb;
  import clmt_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam int LINE_DEPTH     = MAX_ROW_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // Corner values of a Q16.16 field.
  localparam logic signed [31:0] Q_CORNERS [8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sh0000_0001,
    32'sh0000_0001, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000
  };

  // One grid cell as it travels on the input channel.
  typedef struct {
    logic signed [31:0] u_here;
    logic signed [31:0] u_east;
    logic signed [31:0] v_here;
    logic signed [31:0] v_north;
    logic signed [31:0] metric_xi;
    logic signed [31:0] metric_eta;
    logic signed [31:0] cell_height;
    logic signed [31:0] ru_in;
    logic signed [31:0] rv_in;
    logic               update_u;
    logic               update_v;
  } grid_cell_t;

  // Tracks the raster position, the flux history and the expected right-hand sides.
  class rhs_scoreboard;
    logic [CFG_W-1:0]   row_length_reg;
    logic [CFG_W-1:0]   layer_rows_reg;
    int unsigned        column_pos;
    int unsigned        row_pos;
    logic signed [31:0] west_x_flux;
    logic signed [31:0] y_flux_line [LINE_DEPTH];
    bit                 y_flux_written [LINE_DEPTH];
    clmt_res_t          expected_rhs [$];
    int unsigned        fault_count;

    function new();
      row_length_reg = CFG_LEN_RESET;
      layer_rows_reg = CFG_LEN_RESET;
      column_pos     = 0;
      row_pos        = 0;
      west_x_flux    = '0;
      fault_count    = 0;
      foreach (y_flux_written[i]) y_flux_written[i] = 1'b0;
    endfunction

    function void note_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      if (addr == REG_ROW_LENGTH) row_length_reg = data;
      else if (addr == REG_ROWS_PER_LAYER) layer_rows_reg = data;
    endfunction

    // Zero acts as one, anything above the cap acts as the cap.
    function int unsigned clamp_len(logic [CFG_W-1:0] raw, int unsigned cap);
      if (raw == 0) return 1;
      if (raw > cap) return cap;
      return raw;
    endfunction

    function logic signed [31:0] clip32(longint x);
      if (x > Q_MAX) return 32'sh7FFF_FFFF;
      if (x < Q_MIN) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    // Exact sum shifted right by one, rounding toward minus infinity.
    function logic signed [31:0] half_sum(logic signed [31:0] a, logic signed [31:0] b);
      longint s;
      s = (longint'(a) + longint'(b)) >>> 1;
      return s[31:0];
    endfunction

    // Exact product, floor shift by 16, then saturation.
    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = (longint'(a) * longint'(b)) >>> 16;
      return clip32(p);
    endfunction

    // False when the next cell would read a line entry never written since reset.
    function bit line_entry_ready();
      int unsigned col;
      int unsigned row;
      col = (column_pos >= clamp_len(row_length_reg, LINE_DEPTH)) ? 0 : column_pos;
      row = (row_pos >= clamp_len(layer_rows_reg, MAX_LAYER_ROWS)) ? 0 : row_pos;
      return row == 0 || y_flux_written[col];
    endfunction

    // Predict the result of one accepted input beat.
    function void note_cell(grid_cell_t gcell);
      int unsigned        rl;
      int unsigned        rpl;
      int unsigned        col;
      logic signed [31:0] cv;
      logic signed [31:0] cu;
      logic signed [31:0] coef;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      clmt_res_t          want;
      rl  = clamp_len(row_length_reg, LINE_DEPTH);
      rpl = clamp_len(layer_rows_reg, MAX_LAYER_ROWS);
      if (column_pos >= rl) column_pos = 0;
      if (row_pos >= rpl) row_pos = 0;
      col = column_pos;

      cv   = half_sum(gcell.v_here, gcell.v_north);
      cu   = half_sum(gcell.u_here, gcell.u_east);
      coef = qmul(gcell.cell_height,
                  clip32(longint'(qmul(cv, gcell.metric_xi)) -
                         longint'(qmul(cu, gcell.metric_eta))));
      fx   = qmul(coef, cv);
      fy   = qmul(coef, cu);

      want.ru   = gcell.ru_in;
      want.rv   = gcell.rv_in;
      want.ru_w = 1'b0;
      want.rv_w = 1'b0;
      // The first cell of a row has no west neighbor.
      if (gcell.update_u && col > 0) begin
        want.ru   = clip32(longint'(gcell.ru_in) + longint'(half_sum(fx, west_x_flux)));
        want.ru_w = 1'b1;
      end
      // The first row of a layer has no south neighbor.
      if (gcell.update_v && row_pos > 0) begin
        want.rv   = clip32(longint'(gcell.rv_in) - longint'(half_sum(fy, y_flux_line[col])));
        want.rv_w = 1'b1;
      end
      expected_rhs.push_back(want);

      west_x_flux         = fx;
      y_flux_line[col]    = fy;
      y_flux_written[col] = 1'b1;
      column_pos = col + 1;
      if (column_pos >= rl) begin
        column_pos = 0;
        row_pos    = row_pos + 1;
        if (row_pos >= rpl) row_pos = 0;
      end
    endfunction

    // Compare one accepted output beat with the oldest expectation.
    function void check_rhs(clmt_res_t seen);
      clmt_res_t want;
      if (expected_rhs.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("ERROR: result beat with nothing expected: ru %h rv %h w %b%b",
                   seen.ru, seen.rv, seen.ru_w, seen.rv_w);
        fault_count++;
        return;
      end
      want = expected_rhs.pop_front();
      if (seen.ru !== want.ru || seen.rv !== want.rv ||
          seen.ru_w !== want.ru_w || seen.rv_w !== want.rv_w) begin
        if (fault_count < REPORT_LIMIT)
          $display("ERROR: ru %h (exp %h) rv %h (exp %h) ru_w %b (exp %b) rv_w %b (exp %b)",
                   seen.ru, want.ru, seen.rv, want.rv,
                   seen.ru_w, want.ru_w, seen.rv_w, want.rv_w);
        fault_count++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  grid_cell_t            bus_cell;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [31:0]    out_ru_out;
  logic signed [31:0]    out_rv_out;
  logic                  out_ru_written;
  logic                  out_rv_written;

  rhs_scoreboard rhs_board;
  int unsigned   quiet_cycles = 0;
  bit            quiet_tail = 1'b0;
  bit            sender_gaps = 1'b1;
  bit            receiver_stalls = 1'b1;

  curvilinear_momentum_terms_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_u_here      (bus_cell.u_here),
    .in_u_east      (bus_cell.u_east),
    .in_v_here      (bus_cell.v_here),
    .in_v_north     (bus_cell.v_north),
    .in_metric_xi   (bus_cell.metric_xi),
    .in_metric_eta  (bus_cell.metric_eta),
    .in_cell_height (bus_cell.cell_height),
    .in_ru_in       (bus_cell.ru_in),
    .in_rv_in       (bus_cell.rv_in),
    .in_update_u    (bus_cell.update_u),
    .in_update_v    (bus_cell.update_v),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ru_out     (out_ru_out),
    .out_rv_out     (out_rv_out),
    .out_ru_written (out_ru_written),
    .out_rv_written (out_rv_written)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Sample both channels at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) rhs_board.note_cell(bus_cell);
      if (out_valid && !out_stall)
        rhs_board.check_rhs(clmt_res_t'{ru: out_ru_out, rv: out_rv_out,
                                        ru_w: out_ru_written, rv_w: out_rv_written});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End the run if no beat moves on either channel for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver stalls in bursts of random length, released again between bursts.
  initial begin : result_sink
    int unsigned burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && !quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic grid_cell_t make_cell(
      logic signed [31:0] uh, logic signed [31:0] ue, logic signed [31:0] vh,
      logic signed [31:0] vn, logic signed [31:0] mx, logic signed [31:0] me,
      logic signed [31:0] h, logic signed [31:0] ru, logic signed [31:0] rv,
      logic uu, logic uv);
    grid_cell_t gcell;
    gcell.u_here      = uh;
    gcell.u_east      = ue;
    gcell.v_here      = vh;
    gcell.v_north     = vn;
    gcell.metric_xi   = mx;
    gcell.metric_eta  = me;
    gcell.cell_height = h;
    gcell.ru_in       = ru;
    gcell.rv_in       = rv;
    gcell.update_u    = uu;
    gcell.update_v    = uv;
    return gcell;
  endfunction

  // Mostly small and medium magnitudes so that not every product saturates.
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:          return Q_CORNERS[$urandom_range(0, 7)];
      1, 2, 3, 4: return $signed(32'($urandom_range(0, 32'h7_FFFF))) - 32'sh0004_0000;
      5, 6, 7:    return $signed(32'($urandom_range(0, 32'h1FF_FFFF))) - 32'sh0100_0000;
      default:    return $urandom();
    endcase
  endfunction

  function automatic grid_cell_t random_cell();
    return make_cell(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                     pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                     $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
  endfunction

  // Drive one input beat and hold it until it is taken.
  task automatic send_cell(grid_cell_t gcell);
    @(negedge clk);
    // A v update must never read a line entry that was never written.
    if (!rhs_board.line_entry_ready()) gcell.update_v = 1'b0;
    bus_cell = gcell;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Hold the sender until every expected result has come, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (rhs_board.expected_rhs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    rhs_board.note_reg(addr, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Reconfigure while idle and choose the idling pattern of the next phase.
  task automatic enter_phase(int unsigned len, int unsigned rows);
    drain_results();
    load_reg(REG_ROW_LENGTH, len[CFG_W-1:0]);
    load_reg(REG_ROWS_PER_LAYER, rows[CFG_W-1:0]);
    sender_gaps     = !quiet_tail && $urandom_range(0, 3) != 0;
    receiver_stalls = $urandom_range(0, 3) != 0;
  endtask

  task automatic stream_cells(int unsigned count);
    repeat (count) begin
      send_cell(random_cell());
      if (sender_gaps && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 5));
      if (!quiet_tail && $urandom_range(0, 299) == 0) drain_results();
    end
  endtask

  initial begin : stimulus
    int unsigned plan_len   [8] = '{1, 0, 4, 7, 2047, 5, 1024, 16};
    int unsigned plan_rows  [8] = '{1, 0, 3, 1024, 2047, 4, 2, 8};
    int unsigned plan_cells [8] = '{40, 30, 150, 120, 60, 150, 40, 160};
    int unsigned odd_lens   [4] = '{0, 1024, 1025, 2047};
    int unsigned streamed;
    int unsigned len;
    int unsigned rows;
    int unsigned count;

    rhs_board = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ROW_LENGTH;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    bus_cell  = make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset lengths: first cell of the row, saturation both ways, flag mixes.
    send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 1'b1, 1'b1));
    send_cell(make_cell(Q_CORNERS[1], Q_CORNERS[1], Q_CORNERS[1], Q_CORNERS[1],
                        Q_CORNERS[1], Q_CORNERS[0], Q_CORNERS[1], Q_CORNERS[1],
                        Q_CORNERS[0], 1'b1, 1'b1));
    send_cell(make_cell(Q_CORNERS[0], Q_CORNERS[0], Q_CORNERS[0], Q_CORNERS[0],
                        Q_CORNERS[0], Q_CORNERS[0], Q_CORNERS[0], Q_CORNERS[0],
                        Q_CORNERS[0], 1'b1, 1'b1));
    send_cell(make_cell(32'sh0001_8000, 32'sh0000_8000, 32'sh0002_0000, -32'sh0001_0000,
                        32'sh0000_4000, -32'sh0000_C000, 32'sh0003_0000,
                        32'sh000A_0000, -32'sh000A_0000, 1'b1, 1'b0));
    send_cell(make_cell(32'sh0000_2000, -32'sh0000_3000, 32'sh0000_1000, 32'sh0000_7000,
                        -32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000,
                        32'sh0000_0100, -32'sh0000_0100, 1'b0, 1'b1));
    send_cell(make_cell(Q_CORNERS[1], Q_CORNERS[1], Q_CORNERS[1], Q_CORNERS[1],
                        Q_CORNERS[0], Q_CORNERS[1], Q_CORNERS[1], Q_CORNERS[0],
                        Q_CORNERS[1], 1'b1, 1'b1));

    // Short rows and layers: south neighbors, row and layer wrap, corner values.
    enter_phase(3, 2);
    for (int k = 0; k < 18; k++) begin
      send_cell(make_cell(Q_CORNERS[k % 8], Q_CORNERS[(k + 3) % 8],
                          Q_CORNERS[(3 * k + 1) % 8], Q_CORNERS[(5 * k + 2) % 8],
                          Q_CORNERS[(k + 5) % 8], Q_CORNERS[(7 * k + 6) % 8],
                          Q_CORNERS[(3 * k + 4) % 8], Q_CORNERS[(5 * k + 7) % 8],
                          Q_CORNERS[(k + 1) % 8], (k % 3) != 2, (k % 4) != 3));
      if (sender_gaps && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 5));
    end

    // Planned settings, out-of-range lengths among them.
    streamed = 0;
    for (int p = 0; p < 8; p++) begin
      enter_phase(plan_len[p], plan_rows[p]);
      stream_cells(plan_cells[p]);
      streamed += plan_cells[p];
    end

    // Random settings, mostly short rows so that the line store is read often.
    while (streamed < 1050) begin
      len   = ($urandom_range(0, 7) == 0) ? odd_lens[$urandom_range(0, 3)]
                                          : $urandom_range(1, 12);
      rows  = ($urandom_range(0, 7) == 0) ? odd_lens[$urandom_range(0, 3)]
                                          : $urandom_range(1, 6);
      count = $urandom_range(60, 120);
      enter_phase(len, rows);
      stream_cells(count);
      streamed += count;
    end

    // Last part without any idling on either side.
    quiet_tail = 1'b1;
    enter_phase(6, 3);
    stream_cells(100);
    drain_results();

    if (rhs_board.fault_count == 0 && rhs_board.expected_rhs.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clmt_pkg.sv
rtl/clmt_line_store.sv
rtl/clmt_flux_calc.sv
rtl/curvilinear_momentum_terms_top.sv
verif/curvilinear_momentum_terms_top_tb.sv
